>>> rtl/bpe_pkg.sv
// shared constants and types for the bitmap to pixel expander
package bpe_pkg;

  // field widths
  localparam int unsigned SIDE_W  = 13;
  localparam int unsigned ORIG_W  = 12;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned ROWOFF_W = 12;

  // one lane per bit of the input byte
  localparam int unsigned LANES   = 8;
  localparam int unsigned LANE_W  = $clog2(LANES);

  // largest image side honoured, larger settings are clamped
  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(4096);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 3'd5;

  // result of one lane
  typedef struct packed {
    logic               write_pixel;
    logic [COLOR_W-1:0] pixel_color;
    logic [POS_W-1:0]   pixel_col;
  } slot_t;

  // values shared by all slots of one item
  typedef struct packed {
    logic [POS_W-1:0] pixel_row;
    logic             image_done;
  } byte_info_t;

  // clamp a side length to the supported maximum
  function automatic logic [SIDE_W-1:0] limit_side(input logic [SIDE_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : v;
  endfunction

endpackage

>>> rtl/bitmap_to_pixel_expander.sv
// top level: expands bitmap bytes into pixel write slots
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | in_bitmap_byte
//  out     | out_valid / out_stall | out_write_pixel, out_pixel_color,
//          |                       | out_pixel_col, out_pixel_row,
//          |                       | out_last_of_byte, out_image_done
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// eight lanes resolve all slots of an item in the cycle it is accepted; the
// slot buffer then sends one slot per cycle while out_stall is low, and the
// next item is taken in the cycle its predecessor's eighth slot leaves.
// first slot appears in the cycle after acceptance. out_stall holds the slot
// buffer and, through it, the input. reset (synchronous, rst_n low) puts the
// position at the origin and the registers at their defaults; cfg_ready is
// always high.
module bitmap_to_pixel_expander
  import bpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_bitmap_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_write_pixel,
  output logic [COLOR_W-1:0]   out_pixel_color,
  output logic [POS_W-1:0]     out_pixel_col,
  output logic [POS_W-1:0]     out_pixel_row,
  output logic                 out_last_of_byte,
  output logic                 out_image_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [SIDE_W-1:0]   image_width_r, image_height_r;
  logic [ORIG_W-1:0]   origin_col_r, origin_row_r;
  logic [COLOR_W-1:0]  fg_color_r, bg_color_r;
  logic [POS_W-1:0]    col_off_r, col_off_nxt;
  logic [ROWOFF_W-1:0] row_off_r, row_off_nxt;
  logic [SIDE_W-1:0]   width, height;
  logic [POS_W-1:0]    next_col;
  logic [SIDE_W-1:0]   next_row;
  logic                wrap, done;
  logic                accept, free;
  slot_t               slots [LANES];
  byte_info_t          info;
  slot_t               out_slot;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= SIDE_W'(8);
      image_height_r <= SIDE_W'(8);
      origin_col_r   <= '0;
      origin_row_r   <= '0;
      fg_color_r     <= '0;
      bg_color_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[SIDE_W-1:0];
        REG_ORIGIN_COL:   origin_col_r   <= cfg_data[ORIG_W-1:0];
        REG_ORIGIN_ROW:   origin_row_r   <= cfg_data[ORIG_W-1:0];
        REG_FG_COLOR:     fg_color_r     <= cfg_data;
        REG_BG_COLOR:     bg_color_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // wrap and end of image decisions
  assign width    = limit_side(image_width_r);
  assign height   = limit_side(image_height_r);
  assign next_col = col_off_r + POS_W'(LANES);
  assign next_row = SIDE_W'(row_off_r) + 1'b1;
  assign wrap     = next_col >= POS_W'(width);
  assign done     = wrap && (next_row >= height);

  assign accept   = in_valid && free;
  assign in_stall = !free;

  // position update
  always_comb begin
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    if (accept) begin
      if (wrap) begin
        col_off_nxt = '0;
        row_off_nxt = done ? '0 : next_row[ROWOFF_W-1:0];
      end else begin
        col_off_nxt = next_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r <= '0;
      row_off_r <= '0;
    end else begin
      col_off_r <= col_off_nxt;
      row_off_r <= row_off_nxt;
    end
  end

  // lanes, one per bit
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bpe_lane u_lane (
      .bit_val    (in_bitmap_byte[i]),
      .lane_idx   (LANE_W'(i)),
      .col_offset (col_off_r),
      .width      (width),
      .origin_col (origin_col_r),
      .fg_color   (fg_color_r),
      .bg_color   (bg_color_r),
      .slot       (slots[i])
    );
  end

  // row and end flag shared by the item
  assign info.pixel_row  = POS_W'(origin_row_r) + POS_W'(row_off_r);
  assign info.image_done = done;

  // slot buffer and serialiser
  bpe_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .slots     (slots),
    .info      (info),
    .free      (free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_slot  (out_slot),
    .out_row   (out_pixel_row),
    .out_last  (out_last_of_byte),
    .out_done  (out_image_done)
  );

  assign out_write_pixel = out_slot.write_pixel;
  assign out_pixel_color = out_slot.pixel_color;
  assign out_pixel_col   = out_slot.pixel_col;

endmodule

>>> rtl/bpe_lane.sv
// one pixel lane: colour and column for a single bit of the item
module bpe_lane
  import bpe_pkg::*;
(
  input  logic               bit_val,
  input  logic [LANE_W-1:0]  lane_idx,
  input  logic [POS_W-1:0]   col_offset,
  input  logic [SIDE_W-1:0]  width,
  input  logic [ORIG_W-1:0]  origin_col,
  input  logic [COLOR_W-1:0] fg_color,
  input  logic [COLOR_W-1:0] bg_color,
  output slot_t              slot
);

  logic [POS_W-1:0] col;
  logic             col_in_row;
  logic             fg_on;
  logic             bg_on;

  // column inside the bitmap and alpha checks
  assign col        = col_offset + POS_W'(lane_idx);
  assign col_in_row = col < width;
  assign fg_on      = |fg_color[31:24];
  assign bg_on      = |bg_color[31:24];

  // colour selection, padding and transparent slots write nothing
  always_comb begin
    slot.write_pixel = 1'b0;
    slot.pixel_color = '0;
    if (col_in_row) begin
      if (bit_val && fg_on) begin
        slot.write_pixel = 1'b1;
        slot.pixel_color = fg_color;
      end else if (bg_on) begin
        slot.write_pixel = 1'b1;
        slot.pixel_color = bg_color;
      end
    end
    slot.pixel_col = POS_W'(origin_col) + col;
  end

endmodule

>>> rtl/bpe_merge.sv
// holds the lane results of one item and sends them out one slot a cycle while out_stall is low
module bpe_merge
  import bpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  slot_t            slots [LANES],
  input  byte_info_t       info,
  output logic             free,
  input  logic             out_stall,
  output logic             out_valid,
  output slot_t            out_slot,
  output logic [POS_W-1:0] out_row,
  output logic             out_last,
  output logic             out_done
);

  slot_t            buf_r [LANES];
  byte_info_t       info_r;
  logic [LANE_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic             take;
  logic             last;

  // slot handshake
  assign last = idx_r == LANE_W'(LANES - 1);
  assign take = valid_r && !out_stall;
  assign free = !valid_r || (take && last);

  // slot counter and occupancy
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = '0;
      valid_nxt = 1'b1;
    end else if (take) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // item buffer, loaded whole from the lanes
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r  <= slots;
      info_r <= info;
    end
  end

  // outputs
  assign out_valid = valid_r;
  assign out_slot  = buf_r[idx_r];
  assign out_row   = info_r.pixel_row;
  assign out_last  = last;
  assign out_done  = last && info_r.image_done;

endmodule

>>> rtl/bpe_checker.sv
// port level checks for the bitmap to pixel expander
module bpe_checker
  import bpe_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_write_pixel,
  input logic [COLOR_W-1:0] out_pixel_color,
  input logic [POS_W-1:0]   out_pixel_col,
  input logic               out_last_of_byte,
  input logic               out_image_done
);

  // end of image only on the last slot of an item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_last_of_byte)
    else $error("image_done outside the last slot");

  // a new item only enters as the previous item's last slot leaves
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && out_valid |-> out_last_of_byte && !out_stall)
    else $error("item accepted while slots still pending");

  // an accepted item shows its first slot in the next cycle
  a_first_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid && !out_last_of_byte)
    else $error("no slot after accepted item");

  // skipped slots carry no colour
  a_skip_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_pixel |-> out_pixel_color == '0)
    else $error("skipped slot with colour");

  // a stalled slot holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_col))
    else $error("stalled slot changed");

endmodule

bind bitmap_to_pixel_expander bpe_checker u_bpe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_write_pixel  (out_write_pixel),
  .out_pixel_color  (out_pixel_color),
  .out_pixel_col    (out_pixel_col),
  .out_last_of_byte (out_last_of_byte),
  .out_image_done   (out_image_done)
);
